>>> rtl/core/tdp_pkg.sv
// Shared constants, widths and types for the transient ducker with pre-delay.
// No dependencies; imported by transient_ducker_predelay_top.
`default_nettype none

package tdp_pkg;

    // Sizing
    localparam int DELAY_DEPTH = 2048;
    localparam int WINDOW_LEN  = 32;
    localparam int SAMPLE_BITS = 24;

    // Register field widths
    localparam int SCALE_W    = 17;
    localparam int PD_W       = 11;
    localparam int THR_W      = 24;
    localparam int COEF_W     = 16;
    localparam int DEPTH_W    = 17;
    localparam int GATE_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Derived widths
    localparam int DLY_AW = $clog2(DELAY_DEPTH);
    localparam int DLY_CW = (DLY_AW > PD_W) ? DLY_AW : PD_W;
    localparam int WIN_AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    // Shared multiplier: A up to scale*gain (2^32), B a magnitude, Q0.16 or Q1.16 value
    localparam int SG_W   = 33;
    localparam int MB_W   = (SAMPLE_BITS > GATE_W) ? SAMPLE_BITS : GATE_W;
    localparam int PROD_W = SG_W + MB_W;

    localparam int Q16_SHIFT = 16;
    localparam int OUT_SHIFT = 32;

    // Constants
    localparam logic [GATE_W-1:0]      ONE_Q16      = GATE_W'(65536);
    localparam logic [SCALE_W-1:0]     SCALE_BYPASS = SCALE_W'(65530);
    localparam logic [DEPTH_W-1:0]     DEPTH_MIN    = DEPTH_W'(7);
    localparam logic [SUM_W-1:0]       VETO_LEVEL   = SUM_W'(3) << (SAMPLE_BITS - 2);
    localparam logic [SAMPLE_BITS-1:0] SMAX         = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // Reset values of the registers
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);
    localparam logic [THR_W-1:0]   THR_RST   = THR_W'(8388608);
    localparam logic [COEF_W-1:0]  REL_RST   = COEF_W'(65000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_SCALE = 3'd0,
        CFG_PREDELAY    = 3'd1,
        CFG_THRESHOLD   = 3'd2,
        CFG_RELEASE     = 3'd3,
        CFG_DEPTH       = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_GATE,
        ST_DEPTH,
        ST_GAIN,
        ST_SCALE,
        ST_LEFT,
        ST_RIGHT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/transient_ducker_predelay_top.sv
// Transient ducker with ring pre-delay: sequencer, shared multiplier, delay RAM.
// Depends on tdp_pkg.
`default_nettype none

// One stereo word goes from acceptance to a result in the output register through
// the sequencer states, and no new word is taken before it is done. The steps
// follow from a single shared multiplier that forms five products in turn (gate decay,
// depth times gate, scale times gain, then left and right magnitude times that
// gain). in_stall is high while a word is in work; a finished result sits in the
// output register, so the next word may enter while it waits, and the sequencer
// holds only if the previous result has still not been taken at the end.
// The pre-delay RAM needs no clearing pass: a fill mark tracks which entries have
// been written since reset, and unwritten entries read as zero. Configuration is
// always ready and is meant to be written only while the block is idle.
module transient_ducker_predelay_top
    import tdp_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] raw_left,
    input  wire logic signed [SAMPLE_BITS-1:0] raw_right,
    input  wire logic signed [SAMPLE_BITS-1:0] send_left,
    input  wire logic signed [SAMPLE_BITS-1:0] send_right,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      ducked_left,
    output logic signed [SAMPLE_BITS-1:0]      ducked_right,
    output logic        [GATE_W-1:0]           reflection_gate,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    // Configuration
    logic [SCALE_W-1:0] scale_reg;
    logic [PD_W-1:0]    predelay_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [COEF_W-1:0]  rel_reg;
    logic [DEPTH_W-1:0] depth_reg;

    // Control state
    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [DLY_AW-1:0]  pos_reg, pos_next;
    logic               full_reg, full_next;
    logic [WIN_AW-1:0]  wp_reg, wp_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [GATE_W-1:0]  gate_reg, gate_next;
    logic [SAMPLE_BITS-1:0] win_reg  [WINDOW_LEN];
    logic [SAMPLE_BITS-1:0] win_next [WINDOW_LEN];

    // Datapath
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [SAMPLE_BITS-1:0] send_l_reg, send_l_next, send_r_reg, send_r_next;
    logic [SAMPLE_BITS-1:0] src_l_reg, src_l_next, src_r_reg, src_r_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic [GATE_W-1:0]      gain_reg, gain_next;
    logic [SG_W-1:0]        sg_reg, sg_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0] res_l_reg, res_l_next;
    logic [SAMPLE_BITS-1:0] out_l_reg, out_l_next, out_r_reg, out_r_next;
    logic [GATE_W-1:0]      out_g_reg, out_g_next;

    // Pre-delay RAM, left in the upper half of each word
    logic [2*SAMPLE_BITS-1:0] ring_mem [DELAY_DEPTH];
    logic [2*SAMPLE_BITS-1:0] ring_q_reg;
    logic                     ring_we;

    // Combinational helpers
    logic                   active;
    logic                   pd_on;
    logic [SCALE_W-1:0]     scale_eff;
    logic [DEPTH_W-1:0]     depth_eff;
    logic [DLY_CW-1:0]      pd_ext;
    logic [DLY_AW-1:0]      dly;
    logic [DLY_AW-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] abs_l, abs_r, mag_l, mag_r;
    logic [SAMPLE_BITS-1:0] prod_mag;
    logic [SG_W-1:0]        mul_a;
    logic [MB_W-1:0]        mul_b;
    logic                   peak_hit;

    function automatic logic [SAMPLE_BITS-1:0] abs_val(input logic [SAMPLE_BITS-1:0] v);
        abs_val = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // Restore sign and clamp; a negative magnitude of 2^(n-1) is exactly the minimum
    function automatic logic [SAMPLE_BITS-1:0] signed_sat(input logic neg,
                                                         input logic [SAMPLE_BITS-1:0] m);
        if (neg)
            signed_sat = ~m + 1'b1;
        else if (m[SAMPLE_BITS-1])
            signed_sat = SMAX;
        else
            signed_sat = m;
    endfunction

    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign ducked_left     = out_l_reg;
    assign ducked_right    = out_r_reg;
    assign reflection_gate = out_g_reg;

    assign active    = (depth_reg >= DEPTH_MIN);
    assign pd_on     = (predelay_reg != '0);
    assign scale_eff = (scale_reg >= SCALE_BYPASS) ? ONE_Q16 : scale_reg;
    assign depth_eff = (depth_reg > ONE_Q16) ? ONE_Q16 : depth_reg;

    assign pd_ext  = DLY_CW'(predelay_reg);
    assign dly     = (pd_ext > DLY_CW'(DELAY_DEPTH - 1)) ? DLY_AW'(DELAY_DEPTH - 1)
                                                         : DLY_AW'(pd_ext);
    assign rd_addr = (pos_reg >= dly) ? (pos_reg - dly)
                                      : (pos_reg + DLY_AW'(DELAY_DEPTH) - dly);

    assign abs_l    = abs_val(raw_left);
    assign abs_r    = abs_val(raw_right);
    assign mag_l    = abs_val(src_l_reg);
    assign mag_r    = abs_val(src_r_reg);
    assign prod_mag = prod_reg[OUT_SHIFT +: SAMPLE_BITS];
    assign peak_hit = (CMP_W'(peak_reg) > CMP_W'(thr_reg));
    assign ring_we  = (state_reg == ST_WRITE) && pd_on;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_WRITE:
            begin
                mul_a = SG_W'(gate_reg);
                mul_b = MB_W'(rel_reg);
            end
            ST_DEPTH:
            begin
                mul_a = SG_W'(depth_eff);
                mul_b = MB_W'(gate_reg);
            end
            ST_SCALE:
            begin
                mul_a = SG_W'(scale_eff);
                mul_b = MB_W'(gain_reg);
            end
            ST_LEFT:
            begin
                mul_a = prod_reg[SG_W-1:0];
                mul_b = MB_W'(mag_l);
            end
            // kept on through a stalled finish so the right product stays put
            ST_RIGHT, ST_DONE:
            begin
                mul_a = sg_reg;
                mul_b = MB_W'(mag_r);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {{MB_W{1'b0}}, mul_a} * {{SG_W{1'b0}}, mul_b};

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        full_next      = full_reg;
        wp_next        = wp_reg;
        sum_next       = sum_reg;
        gate_next      = gate_reg;
        win_next       = win_reg;
        peak_next      = peak_reg;
        send_l_next    = send_l_reg;
        send_r_next    = send_r_reg;
        src_l_next     = src_l_reg;
        src_r_next     = src_r_reg;
        rd_ok_next     = rd_ok_reg;
        gain_next      = gain_reg;
        sg_next        = sg_reg;
        res_l_next     = res_l_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_g_next     = out_g_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    peak_next   = (abs_l > abs_r) ? abs_l : abs_r;
                    send_l_next = send_left;
                    send_r_next = send_right;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // entry counts as written once the ring has wrapped or it lies behind pos
                rd_ok_next = full_reg || (rd_addr < pos_reg);
                if (active)
                begin
                    sum_next         = sum_reg - SUM_W'(win_reg[wp_reg]) + SUM_W'(peak_reg);
                    win_next[wp_reg] = peak_reg;
                    wp_next = (wp_reg == WIN_AW'(WINDOW_LEN - 1)) ? '0 : (wp_reg + 1'b1);
                end
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (pd_on)
                begin
                    src_l_next = rd_ok_reg ? ring_q_reg[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
                    src_r_next = rd_ok_reg ? ring_q_reg[SAMPLE_BITS-1:0] : '0;
                    if (pos_reg == DLY_AW'(DELAY_DEPTH - 1))
                    begin
                        pos_next  = '0;
                        full_next = 1'b1;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    src_l_next = send_l_reg;
                    src_r_next = send_r_reg;
                end
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                if (active)
                begin
                    if (peak_hit && (sum_reg < VETO_LEVEL))
                        gate_next = ONE_Q16;
                    else if (sum_reg > VETO_LEVEL)
                        gate_next = '0;
                    else
                        gate_next = prod_reg[Q16_SHIFT +: GATE_W];
                end
                state_next = ST_DEPTH;
            end
            ST_DEPTH:
            begin
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                gain_next  = active ? (ONE_Q16 - prod_reg[Q16_SHIFT +: GATE_W]) : ONE_Q16;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_LEFT;
            end
            ST_LEFT:
            begin
                sg_next    = prod_reg[SG_W-1:0];
                state_next = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                res_l_next = signed_sat(src_l_reg[SAMPLE_BITS-1], prod_mag);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_l_next     = res_l_reg;
                    out_r_next     = signed_sat(src_r_reg[SAMPLE_BITS-1], prod_mag);
                    out_g_next     = active ? gate_reg : ONE_Q16;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            full_reg      <= 1'b0;
            wp_reg        <= '0;
            sum_reg       <= '0;
            gate_reg      <= '0;
            win_reg       <= '{default: '0};
            scale_reg     <= SCALE_RST;
            predelay_reg  <= '0;
            thr_reg       <= THR_RST;
            rel_reg       <= REL_RST;
            depth_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            full_reg      <= full_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            gate_reg      <= gate_next;
            win_reg       <= win_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_INPUT_SCALE: scale_reg    <= cfg_data[SCALE_W-1:0];
                    CFG_PREDELAY:    predelay_reg <= cfg_data[PD_W-1:0];
                    CFG_THRESHOLD:   thr_reg      <= cfg_data[THR_W-1:0];
                    CFG_RELEASE:     rel_reg      <= cfg_data[COEF_W-1:0];
                    CFG_DEPTH:       depth_reg    <= cfg_data[DEPTH_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        peak_reg   <= peak_next;
        send_l_reg <= send_l_next;
        send_r_reg <= send_r_next;
        src_l_reg  <= src_l_next;
        src_r_reg  <= src_r_next;
        rd_ok_reg  <= rd_ok_next;
        gain_reg   <= gain_next;
        sg_reg     <= sg_next;
        prod_reg   <= prod_next;
        res_l_reg  <= res_l_next;
        out_l_reg  <= out_l_next;
        out_r_reg  <= out_r_next;
        out_g_reg  <= out_g_next;
    end

    // Pre-delay RAM: read in the read step, write in the write step (never the same entry)
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[pos_reg] <= {send_l_reg, send_r_reg};
        if (state_reg == ST_READ)
            ring_q_reg <= ring_mem[rd_addr];
    end

endmodule

`default_nettype wire
